// ----- rtl/k_way_sorted_merge_top_defines.svh -----
// -----------------------------------------------------------------------------
// k_way_sorted_merge_top_defines
// assertion macros shared by the merge block
// -----------------------------------------------------------------------------
`ifndef K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define K_WAY_SORTED_MERGE_TOP_DEFINES_SVH

// same-cycle implication
`define KWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwm assertion failed");

// next-cycle implication
`define KWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwm assertion failed");

`endif

// ----- rtl/kwm_pkg.sv -----
// -----------------------------------------------------------------------------
// kwm_pkg
// shared types, codes and defaults of the k-way sorted merge
// -----------------------------------------------------------------------------
package kwm_pkg;

  localparam int LanesDef     = 8;
  localparam int LaneDepthDef = 64;

  localparam int LANE_FIELD_W = 3;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  // widest lane index over the supported lane counts
  localparam int LANE_TAG_W   = 6;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // compare unit control, aligned with the read data of the lane memory
  typedef struct packed {
    logic                  clear;
    logic                  cand_valid;
    logic [LANE_TAG_W-1:0] cand_lane;
  } cmp_ctrl_t;

  // compare unit result
  typedef struct packed {
    logic                  found;
    logic [LANE_TAG_W-1:0] lane;
  } min_res_t;

endpackage

// ----- rtl/kwm_in_if.sv -----
// -----------------------------------------------------------------------------
// kwm_in_if
// request channel: push or pop transactions
// -----------------------------------------------------------------------------
interface kwm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     func;
  logic        [kwm_pkg::LANE_FIELD_W-1:0]  lane;
  logic signed [kwm_pkg::VALUE_W-1:0]       value;

  modport source (output valid, output func, output lane, output value, input ready);
  modport sink   (input valid, input func, input lane, input value, output ready);
endinterface

// ----- rtl/kwm_out_if.sv -----
// -----------------------------------------------------------------------------
// kwm_out_if
// result channel: status and popped value
// -----------------------------------------------------------------------------
interface kwm_out_if;
  logic                                valid;
  logic                                ready;
  logic        [kwm_pkg::STATUS_W-1:0] status;
  logic signed [kwm_pkg::VALUE_W-1:0]  smallest;

  modport source (output valid, output status, output smallest, input ready);
  modport sink   (input valid, input status, input smallest, output ready);
endinterface

// ----- rtl/kwm_lane_ram.sv -----
// -----------------------------------------------------------------------------
// kwm_lane_ram
// lane storage, one write and one registered read port
// -----------------------------------------------------------------------------
module kwm_lane_ram #(
  parameter int AddrW = 9
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AddrW-1:0]                   waddr_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [AddrW-1:0]                   raddr_i,
  output logic signed [kwm_pkg::VALUE_W-1:0] rdata_o
);

  localparam int Depth = 1 << AddrW;

  logic signed [kwm_pkg::VALUE_W-1:0] mem_q [Depth];
  logic signed [kwm_pkg::VALUE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kwm_min_unit.sv -----
// -----------------------------------------------------------------------------
// kwm_min_unit
// shared signed compare unit, keeps the running minimum over a lane scan
// -----------------------------------------------------------------------------
module kwm_min_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  kwm_pkg::cmp_ctrl_t                 ctrl_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0] cand_value_i,
  output kwm_pkg::min_res_t                  res_o,
  output logic signed [kwm_pkg::VALUE_W-1:0] best_value_o
);

  logic                                 found_q;
  logic [kwm_pkg::LANE_TAG_W-1:0]       best_lane_q;
  logic signed [kwm_pkg::VALUE_W-1:0]   best_value_q;
  logic                                 take;

  // strict less keeps the lowest lane on equal heads
  assign take = ctrl_i.cand_valid && (!found_q || (cand_value_i < best_value_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_value_q <= cand_value_i;
      best_lane_q  <= ctrl_i.cand_lane;
    end
  end

  assign res_o.found  = found_q;
  assign res_o.lane   = best_lane_q;
  assign best_value_o = best_value_q;

endmodule

// ----- rtl/kwm_ctrl.sv -----
// -----------------------------------------------------------------------------
// kwm_ctrl
// sequencer, lane pointers and counts, result register
// -----------------------------------------------------------------------------
`include "k_way_sorted_merge_top_defines.svh"

module kwm_ctrl #(
  parameter int Lanes     = kwm_pkg::LanesDef,
  parameter int LaneDepth = kwm_pkg::LaneDepthDef
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  // request side
  input  logic                                              in_valid_i,
  output logic                                              in_ready_o,
  input  logic                                              in_func_i,
  input  logic [kwm_pkg::LANE_FIELD_W-1:0]                  in_lane_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0]                in_value_i,
  // result side
  output logic                                              out_valid_o,
  input  logic                                              out_ready_i,
  output logic [kwm_pkg::STATUS_W-1:0]                      out_status_o,
  output logic signed [kwm_pkg::VALUE_W-1:0]                out_smallest_o,
  // lane memory
  output logic                                              ram_we_o,
  output logic [$clog2(Lanes)+$clog2(LaneDepth)-1:0]        ram_waddr_o,
  output logic signed [kwm_pkg::VALUE_W-1:0]                ram_wdata_o,
  output logic                                              ram_re_o,
  output logic [$clog2(Lanes)+$clog2(LaneDepth)-1:0]        ram_raddr_o,
  // compare unit
  output kwm_pkg::cmp_ctrl_t                                cmp_o,
  input  kwm_pkg::min_res_t                                 min_res_i,
  input  logic signed [kwm_pkg::VALUE_W-1:0]                best_value_i
);

  localparam int LW = $clog2(Lanes);
  localparam int DW = $clog2(LaneDepth);
  localparam int CW = $clog2(LaneDepth + 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_PUSH    = 5'b00010,
    ST_SCAN    = 5'b00100,
    ST_DRAIN   = 5'b01000,
    ST_POP_FIN = 5'b10000
  } state_e;

  state_e                              state_q, state_d;
  logic [kwm_pkg::LANE_FIELD_W-1:0]    lane_q;
  logic signed [kwm_pkg::VALUE_W-1:0]  value_q;
  logic [LW-1:0]                       k_q, k_d;
  logic                                cand_valid_q, cand_valid_d;
  logic [LW-1:0]                       cand_lane_q, cand_lane_d;

  logic [DW-1:0]                       rptr_q [Lanes];
  logic [DW-1:0]                       wptr_q [Lanes];
  logic [CW-1:0]                       cnt_q  [Lanes];

  logic                                out_valid_q;
  kwm_pkg::status_e                    status_q, status_d;
  logic signed [kwm_pkg::VALUE_W-1:0]  smallest_q, smallest_d;

  logic                                in_fire;
  logic                                out_free;
  logic                                out_load;
  logic                                cmp_clear;
  logic                                commit_push;
  logic                                commit_pop;
  logic                                lane_ok;
  logic                                push_ok;
  logic [LW-1:0]                       lane_idx;
  logic [LW-1:0]                       sel_idx;
  logic [DW-1:0]                       sel_rptr, sel_wptr, rptr_nxt, wptr_nxt;
  logic [CW-1:0]                       sel_cnt;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign lane_idx = LW'(lane_q);
  assign lane_ok  = ({{(32 - kwm_pkg::LANE_FIELD_W){1'b0}}, lane_q} < 32'(Lanes));

  // one lane selected per cycle for all pointer and count lookups
  always_comb begin
    case (state_q)
      ST_SCAN:    sel_idx = k_q;
      ST_POP_FIN: sel_idx = LW'(min_res_i.lane);
      default:    sel_idx = lane_idx;
    endcase
  end

  assign sel_rptr = rptr_q[sel_idx];
  assign sel_wptr = wptr_q[sel_idx];
  assign sel_cnt  = cnt_q[sel_idx];
  assign rptr_nxt = (sel_rptr == DW'(LaneDepth - 1)) ? '0 : sel_rptr + DW'(1);
  assign wptr_nxt = (sel_wptr == DW'(LaneDepth - 1)) ? '0 : sel_wptr + DW'(1);
  assign push_ok  = lane_ok && (sel_cnt != CW'(LaneDepth));

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    cand_valid_d = 1'b0;
    cand_lane_d  = cand_lane_q;
    cmp_clear    = 1'b0;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    commit_push  = 1'b0;
    commit_pop   = 1'b0;
    out_load     = 1'b0;
    status_d     = status_q;
    smallest_d   = smallest_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func_i == kwm_pkg::FUNC_POP) begin
            state_d   = ST_SCAN;
            k_d       = '0;
            cmp_clear = 1'b1;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          smallest_d = '0;
          if (push_ok) begin
            ram_we_o    = 1'b1;
            commit_push = 1'b1;
            status_d    = kwm_pkg::STATUS_OK;
          end else begin
            status_d = kwm_pkg::STATUS_FULL;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // fetch the head of lane k, compared in the next cycle
        ram_re_o     = (sel_cnt != '0);
        cand_valid_d = (sel_cnt != '0);
        cand_lane_d  = k_q;
        if (k_q == LW'(Lanes - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + LW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_POP_FIN;
      end
      ST_POP_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          if (min_res_i.found) begin
            commit_pop = 1'b1;
            status_d   = kwm_pkg::STATUS_OK;
            smallest_d = best_value_i;
          end else begin
            status_d   = kwm_pkg::STATUS_EMPTY;
            smallest_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      cand_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < Lanes; i++) begin
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      cand_valid_q <= cand_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (commit_push) begin
        wptr_q[sel_idx] <= wptr_nxt;
        cnt_q[sel_idx]  <= sel_cnt + CW'(1);
      end else if (commit_pop) begin
        rptr_q[sel_idx] <= rptr_nxt;
        cnt_q[sel_idx]  <= sel_cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_lane_q <= cand_lane_d;
    status_q    <= status_d;
    smallest_q  <= smallest_d;
    if (in_fire) begin
      lane_q  <= in_lane_i;
      value_q <= in_value_i;
    end
  end

  assign ram_waddr_o = {sel_idx, sel_wptr};
  assign ram_raddr_o = {sel_idx, sel_rptr};
  assign ram_wdata_o = value_q;

  assign cmp_o.clear      = cmp_clear;
  assign cmp_o.cand_valid = cand_valid_q;
  assign cmp_o.cand_lane  = kwm_pkg::LANE_TAG_W'(cand_lane_q);

  assign out_valid_o    = out_valid_q;
  assign out_status_o   = status_q;
  assign out_smallest_o = smallest_q;

  // a pop only removes from a lane that holds a value
  `KWM_ASSERT_IMP(a_pop_from_live_lane, clk_i, rst_ni, commit_pop, sel_cnt != '0)
  // an accepted push grows its lane by exactly one
  `KWM_ASSERT_NEXT(a_push_grows_lane, clk_i, rst_ni, commit_push, cnt_q[$past(sel_idx)] == $past(sel_cnt) + CW'(1))
  // no new request while one is in flight
  `KWM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o)
  // a waiting result is never overwritten
  `KWM_ASSERT_IMP(a_no_result_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !out_load)

endmodule

// ----- rtl/k_way_sorted_merge_top.sv -----
// -----------------------------------------------------------------------------
// k_way_sorted_merge_top
// k-way merge of sorted lanes: push to a lane fifo, pop the smallest head
// -----------------------------------------------------------------------------
//  channel   direction  fields                 meaning
//  in_i      sink       func, lane, value      push value to lane / pop smallest
//  out_o     source     status, smallest       ok, empty or full; popped value
//
//  a push is accepted, then the memory write and pointer update follow
//  a pop scans with the single compare unit, one lane head per cycle through
//    the one read port of the lane memory, then a drain state waits for the
//    registered read data and a final state commits the result
//  reset (rst_ni, async, active low) clears all lane pointers and counts; the
//    lane memory itself is not cleared, entries are read only after a write
//  a stalled result sits in the output register; the sequencer holds its
//    final state until that register is free, the request side stays not ready
// -----------------------------------------------------------------------------
module k_way_sorted_merge_top #(
  parameter int Lanes     = kwm_pkg::LanesDef,
  parameter int LaneDepth = kwm_pkg::LaneDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwm_in_if.sink    in_i,
  kwm_out_if.source out_o
);

  // lane index in the upper address bits, slot in the lower ones
  localparam int AddrW = $clog2(Lanes) + $clog2(LaneDepth);

  logic                               ram_we;
  logic [AddrW-1:0]                   ram_waddr;
  logic signed [kwm_pkg::VALUE_W-1:0] ram_wdata;
  logic                               ram_re;
  logic [AddrW-1:0]                   ram_raddr;
  logic signed [kwm_pkg::VALUE_W-1:0] ram_rdata;

  kwm_pkg::cmp_ctrl_t                 cmp_ctrl;
  kwm_pkg::min_res_t                  min_res;
  logic signed [kwm_pkg::VALUE_W-1:0] best_value;

  // sequencer with per-lane head/tail pointers and fill counts
  kwm_ctrl #(
    .Lanes     (Lanes),
    .LaneDepth (LaneDepth)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .in_func_i      (in_i.func),
    .in_lane_i      (in_i.lane),
    .in_value_i     (in_i.value),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_status_o   (out_o.status),
    .out_smallest_o (out_o.smallest),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .cmp_o          (cmp_ctrl),
    .min_res_i      (min_res),
    .best_value_i   (best_value)
  );

  // all lane queues share one memory
  kwm_lane_ram #(
    .AddrW (AddrW)
  ) u_lane_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // running minimum over the lane heads during a pop scan
  kwm_min_unit u_min_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cmp_ctrl),
    .cand_value_i (ram_rdata),
    .res_o        (min_res),
    .best_value_o (best_value)
  );

endmodule
